// ----- rtl/ddo_pkg.sv -----
package ddo_pkg;

    // Sequencer states of the odometry engine.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_WMUL,
        S_SUM,
        S_TMUL,
        S_DIV,
        S_HEAD,
        S_GMUL,
        S_CSET,
        S_CORD,
        S_POSE,
        S_DONE
    } t_state;

    // Configuration register indexes.
    localparam logic [1:0] REG_LEFT_DIAM  = 2'd0;
    localparam logic [1:0] REG_RIGHT_DIAM = 2'd1;
    localparam logic [1:0] REG_LEFT_OFF   = 2'd2;
    localparam logic [1:0] REG_RIGHT_OFF  = 2'd3;

    // Request kinds carried in tuser.
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_SET    = 1'b1;

    // pi/360 in Q0.32, 2^31/pi scaled for the turn, and the CORDIC gain in Q30.
    localparam logic [25:0] PI_OVER_360 = 26'd37480660;
    localparam logic [29:0] RAD_TO_BAM  = 30'd683565275;
    localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

    // Serial multiply and divide lengths.
    localparam int WMUL_STEPS = 33;
    localparam int TMUL_STEPS = 30;
    localparam int DIV_STEPS  = 83;
    localparam int GMUL_STEPS = 30;

    // Arctangent of 2^-i as a binary angle where 2^31 is pi.
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/differential_drive_odometry.sv -----
// Channel     | Dir | Contents (lowest bits first)
// ------------+-----+------------------------------------------------------------
// s_axis      | in  | tuser: req_type; tdata: left_angle, right_angle, new_x,
//             |     | new_y, new_heading (32 bits each)
// m_axis      | out | tdata: x_pos, y_pos, heading (32 bits each)
// i_cfg_*     | in  | write enable, register index, 16-bit write data
//
// A set request loads the pose when it is accepted, and its result then passes through
// the done state into the output register. An encoder update runs the serial shift-add
// multipliers (33 + 30 + 30 steps), the restoring divider for the turn (83 steps, one
// quotient bit per cycle) and one CORDIC rotation per cycle; a zero track skips the turn
// multiply and divide. Requests are taken one at a time and a finished result waits in
// the output register; the engine stalls only at its final step while that register is full.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24,
    parameter int ANGLE_BITS   = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_angle, right_angle, new_x, new_y, new_heading
    input  logic [159:0] s_axis_tdata,
    // req_type
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // x_pos, y_pos, heading
    output logic [95:0]  m_axis_tdata
);

    // Heading keeps only its top ANGLE_BITS bits.
    localparam logic [31:0] HeadMask = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    ddo_pkg::t_state r_state, n_state;
    logic [6:0]  r_cnt;

    logic [15:0] r_diam_l, r_diam_r, r_off_l, r_off_r;
    logic [31:0] r_px, r_py, r_ph, r_last_l, r_last_r;

    logic        r_negl, r_negr;
    logic [74:0] r_accl, r_accr;
    logic [41:0] r_ml, r_mr;

    logic [52:0] r_adiff;
    logic        r_dneg;
    logic [82:0] r_acc_t;
    logic [24:0] r_rem;
    logic [31:0] r_quo;

    logic [32:0] r_mabs;
    logic        r_mneg;
    logic [62:0] r_acc_g;

    logic signed [35:0] r_cx, r_cy;
    logic signed [33:0] r_cz;

    logic        r_ovalid;
    logic [95:0] r_odata;

    logic        in_acc;
    logic        out_free;
    logic        last_step;
    logic [16:0] track;

    // Request fields.
    logic [31:0] f_left, f_right, f_x, f_y, f_h;
    logic [32:0] dl, dr, magl, magr;

    // Serial step values.
    logic [42:0] suml, sumr;
    logic [53:0] sumt;
    logic [33:0] sumg;
    logic [25:0] rem2;
    logic [24:0] dvsr;
    logic        qbit;

    // Distance rounding and combination.
    logic [75:0] rndl, rndr;
    logic signed [52:0] distl, distr;
    logic signed [53:0] dsum, ddiff, dhalf;
    logic signed [33:0] mean_c;
    logic [31:0] turn;

    // CORDIC helpers.
    logic signed [35:0] x0, xs, ys;
    logic signed [33:0] z0, atan_s;
    logic [4:0]  sidx;
    logic signed [36:0] nx, ny;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign track    = {1'b0, r_off_l} + {1'b0, r_off_r};
    assign dvsr     = {track, 8'd0};

    assign f_left  = s_axis_tdata[31:0];
    assign f_right = s_axis_tdata[63:32];
    assign f_x     = s_axis_tdata[95:64];
    assign f_y     = s_axis_tdata[127:96];
    assign f_h     = s_axis_tdata[159:128];

    assign dl   = {f_left[31], f_left} - {r_last_l[31], r_last_l};
    assign dr   = {f_right[31], f_right} - {r_last_r[31], r_last_r};
    assign magl = dl[32] ? (33'd0 - dl) : dl;
    assign magr = dr[32] ? (33'd0 - dr) : dr;

    assign suml = {1'b0, r_accl[74:33]} + (r_accl[0] ? {1'b0, r_ml} : 43'd0);
    assign sumr = {1'b0, r_accr[74:33]} + (r_accr[0] ? {1'b0, r_mr} : 43'd0);
    assign sumt = {1'b0, r_acc_t[82:30]} + (r_acc_t[0] ? {1'b0, r_adiff} : 54'd0);
    assign sumg = {1'b0, r_acc_g[62:30]} + (r_acc_g[0] ? {1'b0, r_mabs} : 34'd0);
    assign rem2 = {r_rem, r_acc_t[82]};
    assign qbit = rem2 >= {1'b0, dvsr};

    // Wheel distances rounded half away from zero on the magnitude.
    assign rndl  = {1'b0, r_accl} + 76'd8388608;
    assign rndr  = {1'b0, r_accr} + 76'd8388608;
    assign distl = r_negl ? -$signed({1'b0, rndl[75:24]}) : $signed({1'b0, rndl[75:24]});
    assign distr = r_negr ? -$signed({1'b0, rndr[75:24]}) : $signed({1'b0, rndr[75:24]});
    assign dsum  = 54'(distl) + 54'(distr);
    assign ddiff = 54'(distl) - 54'(distr);
    // Halving truncates toward zero.
    assign dhalf = (dsum + (dsum[53] ? 54'sd1 : 54'sd0)) >>> 1;

    always_comb begin
        if (dhalf > 54'sd4294967296) begin
            mean_c = 34'sd4294967296;
        end else if (dhalf < -54'sd4294967296) begin
            mean_c = -34'sd4294967296;
        end else begin
            mean_c = dhalf[33:0];
        end
    end

    assign turn = r_dneg ? (32'd0 - r_quo) : r_quo;

    // CORDIC set-up: gain-scaled distance and a heading folded into +-pi/2.
    always_comb begin
        x0 = r_mneg ? -$signed({3'b0, r_acc_g[62:30]}) : $signed({3'b0, r_acc_g[62:30]});
        z0 = 34'(signed'(r_ph));
        if (z0 > 34'sd1073741824) begin
            z0 = z0 - 34'sd2147483648;
            x0 = -x0;
        end else if (z0 < -34'sd1073741824) begin
            z0 = z0 + 34'sd2147483648;
            x0 = -x0;
        end
    end

    assign sidx   = r_cnt[4:0];
    assign xs     = r_cx >>> sidx;
    assign ys     = r_cy >>> sidx;
    assign atan_s = $signed({2'b0, ddo_pkg::atan_bam(sidx)});

    assign nx = 37'(signed'(r_px)) + 37'(r_cx);
    assign ny = 37'(signed'(r_py)) + 37'(r_cy);

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -37'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb begin
        case (r_state)
            ddo_pkg::S_WMUL: last_step = r_cnt == 7'(ddo_pkg::WMUL_STEPS - 1);
            ddo_pkg::S_TMUL: last_step = r_cnt == 7'(ddo_pkg::TMUL_STEPS - 1);
            ddo_pkg::S_DIV:  last_step = r_cnt == 7'(ddo_pkg::DIV_STEPS - 1);
            ddo_pkg::S_GMUL: last_step = r_cnt == 7'(ddo_pkg::GMUL_STEPS - 1);
            ddo_pkg::S_CORD: last_step = r_cnt == 7'(CORDIC_STEPS - 1);
            default:         last_step = 1'b0;
        endcase
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            ddo_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser[0] == ddo_pkg::REQ_SET) ?
                              ddo_pkg::S_DONE : ddo_pkg::S_PREP;
                end
            end
            ddo_pkg::S_PREP: n_state = ddo_pkg::S_WMUL;
            ddo_pkg::S_WMUL: if (last_step) n_state = ddo_pkg::S_SUM;
            ddo_pkg::S_SUM:  n_state = (track == 17'd0) ? ddo_pkg::S_HEAD : ddo_pkg::S_TMUL;
            ddo_pkg::S_TMUL: if (last_step) n_state = ddo_pkg::S_DIV;
            ddo_pkg::S_DIV:  if (last_step) n_state = ddo_pkg::S_HEAD;
            ddo_pkg::S_HEAD: n_state = ddo_pkg::S_GMUL;
            ddo_pkg::S_GMUL: if (last_step) n_state = ddo_pkg::S_CSET;
            ddo_pkg::S_CSET: n_state = ddo_pkg::S_CORD;
            ddo_pkg::S_CORD: if (last_step) n_state = ddo_pkg::S_POSE;
            ddo_pkg::S_POSE: n_state = ddo_pkg::S_DONE;
            ddo_pkg::S_DONE: if (out_free) n_state = ddo_pkg::S_IDLE;
            default:         n_state = ddo_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state, configuration and pose.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 7'd0;
            r_ovalid <= 1'b0;
            r_diam_l <= 16'd1024;
            r_diam_r <= 16'd1024;
            r_off_l  <= 16'd1792;
            r_off_r  <= 16'd1792;
            r_px     <= 32'd0;
            r_py     <= 32'd0;
            r_ph     <= 32'd0;
            r_last_l <= 32'd0;
            r_last_r <= 32'd0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    ddo_pkg::REG_LEFT_DIAM:  r_diam_l <= i_cfg_wdata;
                    ddo_pkg::REG_RIGHT_DIAM: r_diam_r <= i_cfg_wdata;
                    ddo_pkg::REG_LEFT_OFF:   r_off_l  <= i_cfg_wdata;
                    ddo_pkg::REG_RIGHT_OFF:  r_off_r  <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (last_step) begin
                r_cnt <= 7'd0;
            end else if (r_state == ddo_pkg::S_WMUL || r_state == ddo_pkg::S_TMUL ||
                         r_state == ddo_pkg::S_DIV || r_state == ddo_pkg::S_GMUL ||
                         r_state == ddo_pkg::S_CORD) begin
                r_cnt <= r_cnt + 7'd1;
            end

            if (in_acc) begin
                if (s_axis_tuser[0] == ddo_pkg::REQ_SET) begin
                    r_px <= f_x;
                    r_py <= f_y;
                    r_ph <= f_h & HeadMask;
                end else begin
                    r_last_l <= f_left;
                    r_last_r <= f_right;
                end
            end
            if (r_state == ddo_pkg::S_HEAD) begin
                r_ph <= (r_ph + turn) & HeadMask;
            end
            if (r_state == ddo_pkg::S_POSE) begin
                r_px <= sat32(nx);
                r_py <= sat32(ny);
            end

            if (r_state == ddo_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Serial datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ddo_pkg::S_IDLE: begin
                r_negl <= dl[32];
                r_negr <= dr[32];
                r_accl <= {42'd0, magl};
                r_accr <= {42'd0, magr};
            end
            ddo_pkg::S_PREP: begin
                r_ml <= r_diam_l * ddo_pkg::PI_OVER_360;
                r_mr <= r_diam_r * ddo_pkg::PI_OVER_360;
            end
            ddo_pkg::S_WMUL: begin
                r_accl <= {suml, r_accl[32:1]};
                r_accr <= {sumr, r_accr[32:1]};
            end
            ddo_pkg::S_SUM: begin
                r_dneg  <= ddiff[53];
                r_adiff <= ddiff[53] ? 53'(-ddiff) : ddiff[52:0];
                r_acc_t <= {53'd0, ddo_pkg::RAD_TO_BAM};
                r_rem   <= 25'd0;
                r_quo   <= 32'd0;
                r_mneg  <= mean_c[33];
                r_mabs  <= mean_c[33] ? 33'(-mean_c) : mean_c[32:0];
            end
            ddo_pkg::S_TMUL: begin
                r_acc_t <= {sumt, r_acc_t[29:1]};
            end
            ddo_pkg::S_DIV: begin
                r_acc_t <= {r_acc_t[81:0], 1'b0};
                r_rem   <= qbit ? 25'(rem2 - {1'b0, dvsr}) : rem2[24:0];
                r_quo   <= {r_quo[30:0], qbit};
            end
            ddo_pkg::S_HEAD: begin
                r_acc_g <= {33'd0, ddo_pkg::CORDIC_GAIN};
            end
            ddo_pkg::S_GMUL: begin
                r_acc_g <= {sumg, r_acc_g[29:1]};
            end
            ddo_pkg::S_CSET: begin
                r_cx <= x0;
                r_cy <= 36'sd0;
                r_cz <= z0;
            end
            ddo_pkg::S_CORD: begin
                if (!r_cz[33]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_s;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_s;
                end
            end
            ddo_pkg::S_DONE: begin
                if (out_free) begin
                    r_odata <= {r_ph, r_py, r_px};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // The divider only runs with a non-zero track.
    a_div_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ddo_pkg::S_DIV |-> track != 17'd0)
        else $error("divider running with zero track");

    // The rotation angle stays within a half turn.
    a_cord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ddo_pkg::S_CORD |->
            (r_cz <= 34'sd2147483648 && r_cz >= -34'sd2147483648))
        else $error("CORDIC angle out of range");

    // Finishing a request always leaves a result in the output register.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ddo_pkg::S_DONE && out_free) |=> r_ovalid)
        else $error("result lost on completion");

    // New requests are only taken when the engine is idle.
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ddo_pkg::S_IDLE |-> !s_axis_tready)
        else $error("request accepted while busy");

endmodule
